>>> src/bba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, codes and controller/datapath types of the first-fit
// bitmap allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // bitmap geometry
    localparam int ENTRIES  = 1024;
    localparam int WORD_W   = (ENTRIES < 64) ? ENTRIES : 64;
    localparam int WORDS    = ENTRIES / WORD_W;
    localparam int PTR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIT_W    = $clog2(WORD_W);

    // field widths
    localparam int COUNT_W  = 11;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;
    localparam int CMP_W    = ($clog2(ENTRIES) + 1 > COUNT_W) ?
                              ($clog2(ENTRIES) + 1) : COUNT_W;

    // register port
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;
    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST = 11'd1024;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // operation codes
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_PUT
    } state_t;

    typedef struct packed {
        logic load;
        logic read;
        logic scan;
        logic put;
    } dp_cmd_t;

    typedef struct packed {
        logic done;
        logic out_free;
    } dp_sts_t;

endpackage

>>> src/bba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> src/bba_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer of the allocator: accept, first read, word scan, result hand-off.
// ----------------------------------------------------------------------------
module bba_ctrl
    import bba_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (sts.done)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            S_READ:
            begin
                cmd.read = 1'b1;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            S_PUT:
            begin
                cmd.put = sts.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

>>> src/bba_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_dpath
// Bitmap word RAM, word scan with priority encoder, in-use counter and
// output register.
// ----------------------------------------------------------------------------
module bba_dpath
    import bba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_sts_t             sts,
    input  logic [COUNT_W-1:0]  entry_count,
    input  logic                func,
    input  logic [INDEX_W-1:0]  entry_index,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [INDEX_W-1:0]  alloc_index,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  free_count
);

    logic                func_reg;
    logic [INDEX_W-1:0]  idx_reg;
    logic [PTR_W-1:0]    ptr_reg;
    logic [PTR_W-1:0]    ptr_next;
    logic [COUNT_W-1:0]  used_count_reg;
    logic [COUNT_W-1:0]  used_count_next;
    logic [WORDS-1:0]    row_valid_reg;
    logic                rd_valid_reg;
    logic [INDEX_W-1:0]  res_index_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic                out_valid_reg;
    logic [INDEX_W-1:0]  alloc_index_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [COUNT_W-1:0]  free_count_reg;

    logic [CMP_W-1:0]    ec_ext;
    logic [CMP_W-1:0]    n_eff;
    logic [CMP_W-1:0]    base;
    logic [CMP_W-1:0]    next_base;
    logic [CMP_W-1:0]    full_idx;
    logic [CMP_W-1:0]    in_idx_ext;
    logic [CMP_W-1:0]    idx_ext;
    logic [CMP_W-1:0]    used_ext;
    logic [WORD_W-1:0]   rd_data;
    logic [WORD_W-1:0]   word;
    logic [WORD_W-1:0]   in_range;
    logic [WORD_W-1:0]   free_bits;
    logic [WORD_W-1:0]   wdata;
    logic [BIT_W-1:0]    hit_pos;
    logic                hit;
    logic                last;
    logic                free_ok;
    logic                done;
    logic                we;
    logic                rd_en;
    logic [PTR_W-1:0]    rd_addr;

    // effective entry count, limited to the bitmap size
    assign ec_ext     = CMP_W'(entry_count);
    assign n_eff      = (ec_ext > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : ec_ext;
    assign base       = CMP_W'(ptr_reg) << BIT_W;
    assign next_base  = base + CMP_W'(WORD_W);
    assign in_idx_ext = CMP_W'(entry_index);
    assign idx_ext    = CMP_W'(idx_reg);
    assign used_ext   = CMP_W'(used_count_reg);

    // rows never written read as all free
    assign word = rd_data & {WORD_W{rd_valid_reg}};

    always_comb
    begin
        for (int j = 0; j < WORD_W; j++)
        begin
            in_range[j] = (base + CMP_W'(j)) < n_eff;
        end
    end

    assign free_bits = ~word & in_range;
    assign hit       = |free_bits;

    // lowest free bit of the word
    always_comb
    begin
        hit_pos = '0;
        for (int j = WORD_W - 1; j >= 0; j--)
        begin
            if (free_bits[j])
            begin
                hit_pos = BIT_W'(j);
            end
        end
    end

    assign full_idx = base + CMP_W'(hit_pos);
    assign last     = (next_base >= n_eff) || (ptr_reg == PTR_W'(WORDS - 1));
    assign free_ok  = idx_ext < n_eff;
    assign done     = (func_reg == FUNC_FREE) || hit || last;

    assign we    = cmd.scan && ((func_reg == FUNC_FREE) ? free_ok : hit);
    assign wdata = (func_reg == FUNC_FREE) ?
                   (word & ~(WORD_W'(1) << idx_ext[BIT_W-1:0])) :
                   (word | (WORD_W'(1) << hit_pos));

    // next word is fetched while the current one is examined
    assign rd_en   = cmd.read || (cmd.scan && !done);
    assign rd_addr = cmd.read ? ptr_reg : (ptr_reg + PTR_W'(1));

    bba_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .clk   (clk),
        .we    (we),
        .waddr (ptr_reg),
        .wdata (wdata),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.load)
        begin
            ptr_next = (func == FUNC_FREE) ? in_idx_ext[BIT_W +: PTR_W] : '0;
        end
        else if (cmd.scan && !done)
        begin
            ptr_next = ptr_reg + PTR_W'(1);
        end
    end

    always_comb
    begin
        used_count_next = used_count_reg;
        if (cmd.scan && done)
        begin
            if (func_reg == FUNC_ALLOC)
            begin
                if (hit && (used_count_reg != COUNT_MAX))
                begin
                    used_count_next = used_count_reg + COUNT_W'(1);
                end
            end
            else if (free_ok && (used_count_reg != '0))
            begin
                used_count_next = used_count_reg - COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_count_reg <= '0;
            row_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            used_count_reg <= used_count_next;
            if (we)
            begin
                row_valid_reg[ptr_reg] <= 1'b1;
            end
            if (cmd.put)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.load)
        begin
            func_reg <= func;
            idx_reg  <= entry_index;
        end
        if (rd_en)
        begin
            rd_valid_reg <= row_valid_reg[rd_addr];
        end
        if (cmd.scan && done)
        begin
            if (func_reg == FUNC_FREE)
            begin
                res_index_reg  <= '0;
                res_status_reg <= free_ok ? ST_OK : ST_RANGE;
            end
            else
            begin
                res_index_reg  <= hit ? full_idx[INDEX_W-1:0] : '0;
                res_status_reg <= hit ? ST_OK : ST_FULL;
            end
        end
        if (cmd.put)
        begin
            alloc_index_reg <= res_index_reg;
            status_reg      <= res_status_reg;
            free_count_reg  <= (n_eff > used_ext) ? COUNT_W'(n_eff - used_ext) : '0;
        end
    end

    assign sts.done     = done;
    assign sts.out_free = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign alloc_index = alloc_index_reg;
    assign status      = status_reg;
    assign free_count  = free_count_reg;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg == ST_OK || status_reg == ST_FULL ||
                           status_reg == ST_RANGE))
        else $error("result carries an undefined status code");

    a_alloc_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.scan && func_reg == FUNC_ALLOC && hit) |-> (full_idx < n_eff))
        else $error("allocated entry beyond the entry count");

    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.scan && done) |=> $stable(used_count_reg))
        else $error("in-use count moved outside a completing scan");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put |-> !(out_valid_reg && out_stall))
        else $error("pending result overwritten");

    a_rw_rows_differ: assert property (@(posedge clk) disable iff (!rst_n)
        (rd_en && we) |-> (rd_addr != ptr_reg))
        else $error("read and write hit the same bitmap row");

endmodule

>>> src/block_bitmap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_bitmap_allocator
// First-fit allocator over a 1024-entry bitmap with an in-use counter.
//
// Input channel (in_valid / in_stall) carries func and entry_index: func
// allocate takes the lowest free entry below entry_count, func free releases
// entry_index. Each transaction gives one result on the output channel
// (out_valid / out_stall): alloc_index, status and the free count after it.
// The bitmap sits in a 16 x 64-bit RAM; allocation walks it one word per
// cycle through a priority encoder. A transaction passes the read, scan
// and put states from acceptance to result, scan covering k words (1 for
// free, 1 to 16 for allocate), and the next one is taken the cycle after
// the result is registered. A result waiting in the output register does
// not block the next transaction until its own result is due. Under
// out_stall the result holds until taken. Reset clears the bitmap at once
// through per-row valid bits (no clearing pass), zeroes the in-use count
// and sets entry_count to 1024. entry_count lies at APB address 0; the
// user must write it only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module block_bitmap_allocator
    import bba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    // request channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                func,
    input  logic [INDEX_W-1:0]  entry_index,
    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic [INDEX_W-1:0]  alloc_index,
    output logic [STATUS_W-1:0] status,
    output logic [COUNT_W-1:0]  free_count
);

    logic [COUNT_W-1:0] entry_count_reg;
    logic               cfg_wr;
    dp_cmd_t            cmd;
    dp_sts_t            sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT);
    assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? PDATA_W'(entry_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= ENTRY_COUNT_RST;
        end
        else if (cfg_wr)
        begin
            entry_count_reg <= pwdata[COUNT_W-1:0];
        end
    end

    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    bba_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .entry_count (entry_count_reg),
        .func        (func),
        .entry_index (entry_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .alloc_index (alloc_index),
        .status      (status),
        .free_count  (free_count)
    );

endmodule

>>> sim/bba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_checker
// Watches the register port and both channels of the bitmap allocator. It
// keeps its own copy of the bitmap, the in-use count and entry_count, works
// out the outcome of every accepted request and compares each result field
// with the oldest outcome still waiting. Register reads are checked as well.
// ----------------------------------------------------------------------------
module bba_checker
    import bba_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    input  logic [PDATA_W-1:0]  prdata,
    input  logic                pready,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                func,
    input  logic [INDEX_W-1:0]  entry_index,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [INDEX_W-1:0]  alloc_index,
    input  logic [STATUS_W-1:0] status,
    input  logic [COUNT_W-1:0]  free_count,
    output int                  fail_count,
    output int                  outstanding,
    output int                  full_count,
    output int                  range_count
);

    localparam logic [PADDR_W-1:0] ENTRY_COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};

    typedef struct packed {
        logic [INDEX_W-1:0]  index;
        logic [STATUS_W-1:0] code;
        logic [COUNT_W-1:0]  avail;
    } outcome_t;

    logic                used_map [ENTRIES];
    logic [COUNT_W-1:0]  in_use;
    logic [COUNT_W-1:0]  cfg_entries;
    outcome_t            pending_outcomes [$];

    // applies one request to the tracked bitmap and returns its result
    function automatic outcome_t next_outcome(input logic op,
                                              input logic [INDEX_W-1:0] idx);
        int unsigned span;
        int unsigned i;
        bit          found;
        outcome_t    o;
        span  = (cfg_entries > ENTRIES) ? ENTRIES : cfg_entries;
        o     = '0;
        found = 1'b0;
        if (op == FUNC_ALLOC)
        begin
            o.code = ST_FULL;
            for (i = 0; i < span && !found; i++)
            begin
                if (!used_map[i])
                begin
                    used_map[i] = 1'b1;
                    if (in_use < COUNT_MAX)
                        in_use++;
                    o.index = i[INDEX_W-1:0];
                    o.code  = ST_OK;
                    found   = 1'b1;
                end
            end
        end
        else if (idx < span)
        begin
            // an already clear entry still lowers the count
            used_map[idx] = 1'b0;
            if (in_use > 0)
                in_use--;
        end
        else
        begin
            o.code = ST_RANGE;
        end
        o.avail = (span > in_use) ? COUNT_W'(span - in_use) : '0;
        return o;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        outcome_t want;
        if (!rst_n)
        begin
            for (int j = 0; j < ENTRIES; j++)
                used_map[j] = 1'b0;
            in_use      = '0;
            cfg_entries = ENTRY_COUNT_RST;
            pending_outcomes.delete();
            outstanding = 0;
        end
        else
        begin
            if (psel && penable && pready && paddr == ENTRY_COUNT_ADDR)
            begin
                if (pwrite)
                    cfg_entries = pwdata[COUNT_W-1:0];
                else if (prdata !== PDATA_W'(cfg_entries))
                begin
                    $display("%0t: entry_count read mismatch, expected %0d, got %0d",
                             $time, cfg_entries, prdata);
                    fail_count++;
                end
            end

            // result transaction first, so a new request cannot cover a stray one
            if (out_valid && !out_stall)
            begin
                if (pending_outcomes.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got %0d/%0d/%0d",
                             $time, alloc_index, status, free_count);
                    fail_count++;
                end
                else
                begin
                    want = pending_outcomes.pop_front();
                    if (alloc_index !== want.index)
                    begin
                        $display("%0t: alloc_index mismatch, expected %0d, got %0d",
                                 $time, want.index, alloc_index);
                        fail_count++;
                    end
                    if (status !== want.code)
                    begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.code, status);
                        fail_count++;
                    end
                    if (free_count !== want.avail)
                    begin
                        $display("%0t: free_count mismatch, expected %0d, got %0d",
                                 $time, want.avail, free_count);
                        fail_count++;
                    end
                end
            end

            if (in_valid && !in_stall)
            begin
                want = next_outcome(func, entry_index);
                if (want.code == ST_FULL)
                    full_count++;
                if (want.code == ST_RANGE)
                    range_count++;
                pending_outcomes.push_back(want);
            end
            outstanding = pending_outcomes.size();
        end
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the first-fit bitmap allocator with a short directed sequence and
// then phases of random allocate and free requests under several entry_count
// settings and idling patterns. The checker beside the block predicts and
// compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import bba_pkg::*;

    localparam logic [PADDR_W-1:0] ENTRY_COUNT_ADDR = {REG_ENTRY_COUNT, 2'b00};

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [PADDR_W-1:0]  paddr       = '0;
    logic [PDATA_W-1:0]  pwdata      = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic                func        = FUNC_ALLOC;
    logic [INDEX_W-1:0]  entry_index = '0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic [INDEX_W-1:0]  alloc_index;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_count;

    int fail_count;
    int outstanding;
    int full_count;
    int range_count;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int alloc_sent     = 0;
    int free_sent      = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    block_bitmap_allocator u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .entry_index (entry_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .alloc_index (alloc_index),
        .status      (status),
        .free_count  (free_count)
    );

    bba_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .entry_index (entry_index),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .alloc_index (alloc_index),
        .status      (status),
        .free_count  (free_count),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .full_count  (full_count),
        .range_count (range_count)
    );

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_request(input logic op, input logic [INDEX_W-1:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        func        <= op;
        entry_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (op == FUNC_ALLOC)
            alloc_sent++;
        else
            free_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // write then read back, each as setup and access cycles
    task automatic write_entry_count(input int value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= ENTRY_COUNT_ADDR;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode)
            1:       begin send_idle_pct = 53; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 53; end
            3:       begin send_idle_pct = 13; recv_stall_pct = 13; end
            default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    task automatic run_phase(input int entries, input int items, input int alloc_pct,
                             input int free_max, input int mode);
        int                 k;
        logic [INDEX_W-1:0] idx;
        wait_drained();
        write_entry_count(entries);
        set_idling(mode);
        for (k = 0; k < items; k++)
        begin
            // mostly frees of entries likely in use, some anywhere
            if ($urandom_range(99) < 80)
                idx = INDEX_W'($urandom_range(free_max));
            else
                idx = INDEX_W'($urandom_range(1023));
            send_request(($urandom_range(99) < alloc_pct) ? FUNC_ALLOC : FUNC_FREE, idx);
        end
    endtask

    initial
    begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset setting first
        send_request(FUNC_ALLOC, 10'h3FF);
        send_request(FUNC_ALLOC, 10'h000);
        send_request(FUNC_ALLOC, 10'h155);
        send_request(FUNC_FREE,  10'd1);
        send_request(FUNC_ALLOC, 10'h2AA);
        send_request(FUNC_FREE,  10'd1023);
        send_request(FUNC_FREE,  10'd0);
        send_request(FUNC_FREE,  10'd0);
        send_request(FUNC_FREE,  10'h2AA);
        send_request(FUNC_FREE,  10'h155);
        // no entries at all
        wait_drained();
        write_entry_count(0);
        send_request(FUNC_ALLOC, 10'd0);
        send_request(FUNC_FREE,  10'd0);
        // above the bitmap size acts as the full size
        wait_drained();
        write_entry_count(2047);
        send_request(FUNC_ALLOC, 10'd0);
        send_request(FUNC_ALLOC, 10'd0);
        send_request(FUNC_ALLOC, 10'd0);
        send_request(FUNC_FREE,  10'd1023);
        // in-use count now equal to the entry count
        wait_drained();
        write_entry_count(2);
        send_request(FUNC_ALLOC, 10'd0);
        send_request(FUNC_FREE,  10'd5);
        send_request(FUNC_FREE,  10'd1);
        wait_drained();
        write_entry_count(1);
        send_request(FUNC_ALLOC, 10'd0);
        send_request(FUNC_FREE,  10'd1);
        send_request(FUNC_FREE,  10'd0);

        // random: fill most of the map, then small and odd entry counts
        run_phase(1024, 350, 95, 1023, 0);
        run_phase(1024, 400, 90, 1023, 1);
        run_phase(1024, 350, 85, 1023, 2);
        run_phase(2047, 150, 95, 1023, 3);
        run_phase(40,   200, 50, 63,   0);
        run_phase(1,    100, 50, 3,    1);
        run_phase(0,    60,  50, 7,    2);
        run_phase(300,  150, 60, 511,  3);
        run_phase(1024, 140, 40, 1023, 0);

        wait_drained();
        repeat (40) @(negedge clk);
        $display("covered %0d requests: %0d allocate, %0d free, entry counts 0 to 2047",
                 alloc_sent + free_sent, alloc_sent, free_sent);
        $display("saw %0d full and %0d out-of-range outcomes across four idling modes",
                 full_count, range_count);
        if (fail_count == 0 && outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
